FILE: hw/rtl/od16_pkg.sv
// ----------------------------------------------------------------------------
// od16_pkg
// Shared types and constants for the ordered dither to 16-bit pixel block.
// ----------------------------------------------------------------------------
package od16_pkg;

    localparam int MAX_DIM_DEFAULT = 4096;
    localparam int DIM_CFG_W       = 13;
    localparam int CFG_IDX_W       = 8;
    localparam int CFG_DATA_W      = 16;
    localparam int RANK_W          = 4;

    localparam logic [DIM_CFG_W-1:0] DIM_RESET = 13'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PIXEL_FORMAT = 8'd0,
        REG_FLIP_ROWS    = 8'd1,
        REG_IMAGE_WIDTH  = 8'd2,
        REG_IMAGE_HEIGHT = 8'd3
    } cfg_reg_t;

    typedef enum logic {
        FMT_RGBA4444 = 1'b0,
        FMT_RGB565   = 1'b1
    } pixel_fmt_t;

    // 4x4 Bayer pattern, each value less one (pattern 1..16 becomes 0..15)
    localparam logic [RANK_W-1:0] BAYER_RANK [16] = '{
        4'd0,  4'd8,  4'd2,  4'd10,
        4'd12, 4'd4,  4'd14, 4'd6,
        4'd3,  4'd11, 4'd1,  4'd9,
        4'd15, 4'd7,  4'd13, 4'd5
    };

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        pixel_fmt_t        fmt;
        logic              last;
    } stage_ctl_t;

endpackage

FILE: hw/rtl/ordered_dither_to_16bit_pixel.sv
// ----------------------------------------------------------------------------
// ordered_dither_to_16bit_pixel
// 4x4 ordered dither of RGBA8888 raster pixels to RGBA4444 or RGB565.
// ----------------------------------------------------------------------------
// Pipeline: the input beat is registered in the input stage, then the result in the result stage.
// Throughput: one pixel per cycle; only output back-pressure stalls the pipe.
// The pattern lookup feeds the input stage; the saturating add feeds the result stage.
// Reset: counters cleared, format RGBA4444, no flip, 256x256 image, pipe empty.
// Configuration writes are taken every cycle and do not clear the counters.
module ordered_dither_to_16bit_pixel #(
    parameter int MAX_DIM = od16_pkg::MAX_DIM_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [od16_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [od16_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     red_in,
    input  logic [7:0]                     green_in,
    input  logic [7:0]                     blue_in,
    input  logic [7:0]                     alpha_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [15:0]                    packed_pixel,
    output logic                           last_pixel
);
    import od16_pkg::*;

    localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int MAX_W = $clog2(MAX_DIM + 1);
    localparam int CMP_W = (MAX_W > DIM_CFG_W) ? MAX_W : DIM_CFG_W;
    localparam logic [CMP_W-1:0] MAX_DIM_C = CMP_W'(MAX_DIM);

    pixel_fmt_t           fmt_reg;
    logic                 flip_reg;
    logic [DIM_CFG_W-1:0] width_reg;
    logic [DIM_CFG_W-1:0] height_reg;

    logic [CNT_W-1:0]     col_reg;
    logic [CNT_W-1:0]     col_next;
    logic [CNT_W-1:0]     row_reg;
    logic [CNT_W-1:0]     row_next;

    logic                 s1_valid_reg;
    logic [7:0]           s1_red_reg;
    logic [7:0]           s1_green_reg;
    logic [7:0]           s1_blue_reg;
    logic [7:0]           s1_alpha_reg;
    stage_ctl_t           s1_ctl_reg;
    stage_ctl_t           s1_ctl_next;

    logic                 out_valid_reg;
    logic [15:0]          pixel_reg;
    logic                 last_reg;
    logic [15:0]          pixel_next;

    logic [CMP_W-1:0]     width_ext;
    logic [CMP_W-1:0]     height_ext;
    logic [CMP_W-1:0]     width_eff;
    logic [CMP_W-1:0]     height_eff;
    logic                 end_row;
    logic                 end_img;
    logic [1:0]           prow;
    logic                 in_beat;
    logic                 s1_adv;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= FMT_RGBA4444;
            flip_reg   <= 1'b0;
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PIXEL_FORMAT: fmt_reg    <= pixel_fmt_t'(cfg_data[0]);
                REG_FLIP_ROWS:    flip_reg   <= cfg_data[0];
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[DIM_CFG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[DIM_CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    // zero acts as one, oversize acts as the maximum
    assign width_ext  = CMP_W'(width_reg);
    assign height_ext = CMP_W'(height_reg);
    assign width_eff  = (width_ext == '0) ? CMP_W'(1) :
                        (width_ext > MAX_DIM_C) ? MAX_DIM_C : width_ext;
    assign height_eff = (height_ext == '0) ? CMP_W'(1) :
                        (height_ext > MAX_DIM_C) ? MAX_DIM_C : height_ext;

    assign end_row = CMP_W'(col_reg) >= (width_eff - CMP_W'(1));
    assign end_img = CMP_W'(row_reg) >= (height_eff - CMP_W'(1));

    assign prow = flip_reg ? (height_eff[1:0] - 2'd1 - row_reg[1:0]) : row_reg[1:0];

    always_comb
    begin
        s1_ctl_next.rank = BAYER_RANK[{prow, col_reg[1:0]}];
        s1_ctl_next.fmt  = fmt_reg;
        s1_ctl_next.last = end_row && end_img;
    end

    always_comb
    begin
        if (end_row)
        begin
            col_next = '0;
            row_next = end_img ? '0 : row_reg + CNT_W'(1);
        end
        else
        begin
            col_next = col_reg + CNT_W'(1);
            row_next = row_reg;
        end
    end

    assign s1_adv   = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_beat  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_beat)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            s1_red_reg   <= red_in;
            s1_green_reg <= green_in;
            s1_blue_reg  <= blue_in;
            s1_alpha_reg <= alpha_in;
            s1_ctl_reg   <= s1_ctl_next;
        end
    end

    od16_pack u_pack (
        .ctl   (s1_ctl_reg),
        .red   (s1_red_reg),
        .green (s1_green_reg),
        .blue  (s1_blue_reg),
        .alpha (s1_alpha_reg),
        .pixel (pixel_next)
    );

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            pixel_reg <= pixel_next;
            last_reg  <= s1_ctl_reg.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign packed_pixel = pixel_reg;
    assign last_pixel   = last_reg;

    a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && end_row |=> col_reg == '0)
        else $error("column counter did not wrap at end of row");

    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && !end_row |=> col_reg == $past(col_reg) + CNT_W'(1))
        else $error("column counter did not advance");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_ctl_reg))
        else $error("input stage beat dropped while stalled");

    a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_ready && !s1_valid_reg |=> !out_valid_reg)
        else $error("result beat repeated after drain");

endmodule

FILE: hw/rtl/od16_pack.sv
// ----------------------------------------------------------------------------
// od16_pack
// Adds the dither offset to red, green and blue, saturates, reduces and packs the pixel.
// ----------------------------------------------------------------------------
module od16_pack (
    input  od16_pkg::stage_ctl_t ctl,
    input  logic [7:0]           red,
    input  logic [7:0]           green,
    input  logic [7:0]           blue,
    input  logic [7:0]           alpha,
    output logic [15:0]          pixel
);
    import od16_pkg::*;

    function automatic logic [7:0] sat_add(input logic [7:0] c, input logic [RANK_W-1:0] off);
        logic [8:0] sum;
        sum = {1'b0, c} + {5'd0, off};
        return sum[8] ? 8'hFF : sum[7:0];
    endfunction

    logic [RANK_W-1:0] off4;
    logic [RANK_W-1:0] off3;
    logic [RANK_W-1:0] off2;
    logic [7:0]        r4;
    logic [7:0]        g4;
    logic [7:0]        b4;
    logic [7:0]        r3;
    logic [7:0]        g2;
    logic [7:0]        b3;

    // 2^s * n / 17 equals (n - 1) >> (4 - s) for n in 1..16
    assign off4 = ctl.rank;
    assign off3 = ctl.rank >> 1;
    assign off2 = ctl.rank >> 2;

    assign r4 = sat_add(red, off4);
    assign g4 = sat_add(green, off4);
    assign b4 = sat_add(blue, off4);
    assign r3 = sat_add(red, off3);
    assign g2 = sat_add(green, off2);
    assign b3 = sat_add(blue, off3);

    always_comb
    begin
        unique case (ctl.fmt)
            FMT_RGBA4444: pixel = {r4[7:4], g4[7:4], b4[7:4], alpha[7:4]};
            FMT_RGB565:   pixel = {r3[7:3], g2[7:2], b3[7:3]};
            default:      pixel = '0;
        endcase
    end

endmodule
